### rtl/animation_frame_sequencer_assert.svh
// ----------------------------------------------------------------------------
// Animation frame sequencer assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ANIMATION_FRAME_SEQUENCER_ASSERT_SVH
`define ANIMATION_FRAME_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define AFS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afs check failed");
// Antecedent implies consequent in the next cycle.
`define AFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afs check failed");
`else
`define AFS_ASSERT_SAME(label, ante, cons)
`define AFS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### rtl/afs_pkg.sv
// ----------------------------------------------------------------------------
// Animation frame sequencer package
// Shared constants, codes and item types.
// ----------------------------------------------------------------------------
package afs_pkg;

    localparam int MAX_FRAMES = 16;
    localparam int FRAME_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);
    localparam int ENTRY_W    = 4;
    localparam int DELAY_W    = 16;
    localparam int TIME_W     = 32;
    localparam int LOOP_W     = 16;
    localparam int FIU_W      = 5;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic CFG_FRAMES_IN_USE = 1'b0;
    localparam logic CFG_LOOP_LIMIT    = 1'b1;

    typedef struct packed {
        logic [1:0]         action;
        logic [ENTRY_W-1:0] entry;
        logic [DELAY_W-1:0] delay_value;
        logic [TIME_W-1:0]  now_ms;
    } item_t;

    typedef struct packed {
        logic               shown;
        logic [ENTRY_W-1:0] frame_shown;
        logic               running;
    } result_t;

endpackage

### rtl/afs_delay_table.sv
// ----------------------------------------------------------------------------
// Frame delay table
// One write port and one read port over the per-frame display times.
// ----------------------------------------------------------------------------
module afs_delay_table (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [afs_pkg::FRAME_W-1:0]   wr_addr,
    input  logic [afs_pkg::DELAY_W-1:0]   wr_data,
    input  logic [afs_pkg::FRAME_W-1:0]   rd_addr,
    output logic [afs_pkg::DELAY_W-1:0]   rd_data
);

    // Entries hold nothing meaningful until written, so they get no reset.
    logic [afs_pkg::DELAY_W-1:0] table_reg [afs_pkg::MAX_FRAMES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_reg[wr_addr] <= wr_data;
        end
    end

    assign rd_data = table_reg[rd_addr];

endmodule

### rtl/afs_sequencer.sv
// ----------------------------------------------------------------------------
// Frame sequencer core
// Holds playback state and works out the result of one item per step.
// ----------------------------------------------------------------------------
module afs_sequencer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  afs_pkg::item_t               item,
    input  logic [afs_pkg::FIU_W-1:0]    frames_in_use,
    input  logic [afs_pkg::LOOP_W-1:0]   loop_limit,
    output afs_pkg::result_t             result
);

    logic [afs_pkg::FRAME_W-1:0] position_reg, position_next;
    logic [afs_pkg::LOOP_W-1:0]  loops_reg, loops_next;
    logic [afs_pkg::TIME_W-1:0]  deadline_reg, deadline_next;
    logic                        active_reg, active_next;

    logic                        wr_en;
    logic [afs_pkg::DELAY_W-1:0] cur_delay;
    logic [afs_pkg::TIME_W-1:0]  elapsed;
    logic                        due;
    logic [afs_pkg::FIU_W-1:0]   eff_count;
    logic [afs_pkg::FIU_W-1:0]   pos_inc;
    logic [afs_pkg::LOOP_W-1:0]  loops_inc;

    assign wr_en = step && (item.action == afs_pkg::ACT_WRITE)
                   && (int'(item.entry) < afs_pkg::MAX_FRAMES);

    afs_delay_table u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (item.entry[afs_pkg::FRAME_W-1:0]),
        .wr_data (item.delay_value),
        .rd_addr (position_reg),
        .rd_data (cur_delay)
    );

    // The deadline has passed when it is zero or when now minus deadline falls in the lower half
    // of the 32-bit range, which survives wraparound of the millisecond count.
    assign elapsed   = item.now_ms - deadline_reg;
    assign due       = (deadline_reg == '0) || !elapsed[afs_pkg::TIME_W-1];
    assign eff_count = (frames_in_use > afs_pkg::FIU_W'(afs_pkg::MAX_FRAMES))
                       ? afs_pkg::FIU_W'(afs_pkg::MAX_FRAMES) : frames_in_use;
    assign pos_inc   = afs_pkg::FIU_W'(position_reg) + afs_pkg::FIU_W'(1);
    assign loops_inc = loops_reg + afs_pkg::LOOP_W'(1);

    always_comb
    begin
        position_next      = position_reg;
        loops_next         = loops_reg;
        deadline_next      = deadline_reg;
        active_next        = active_reg;
        result.shown       = 1'b0;
        result.frame_shown = '0;
        case (item.action)
            afs_pkg::ACT_START:
            begin
                position_next = '0;
                loops_next    = '0;
                deadline_next = '0;
                active_next   = 1'b1;
            end
            afs_pkg::ACT_TICK:
            begin
                if (active_reg && due)
                begin
                    result.shown       = 1'b1;
                    result.frame_shown = afs_pkg::ENTRY_W'(position_reg);
                    deadline_next      = item.now_ms + afs_pkg::TIME_W'(cur_delay);
                    position_next      = pos_inc[afs_pkg::FRAME_W-1:0];
                    // A completed pass wraps to the first frame and, when a loop limit is set, counts a loop.
                    if (pos_inc >= eff_count)
                    begin
                        position_next = '0;
                        if (loop_limit != '0)
                        begin
                            loops_next = loops_inc;
                            if (loops_inc >= loop_limit)
                            begin
                                active_next = 1'b0;
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        result.running = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            loops_reg    <= '0;
            deadline_reg <= '0;
            active_reg   <= 1'b0;
        end
        else if (step)
        begin
            position_reg <= position_next;
            loops_reg    <= loops_next;
            deadline_reg <= deadline_next;
            active_reg   <= active_next;
        end
    end

endmodule

### rtl/animation_frame_sequencer.sv
// ----------------------------------------------------------------------------
// Animation frame sequencer
// Times animation frames against a millisecond count and reports each show.
// ----------------------------------------------------------------------------
// Input items arrive on the s_ channel: s_tuser carries the action (write a
// frame delay, start playback, or time tick) and s_tdata the frame index,
// delay and current millisecond time. Every item yields exactly one result
// on the m_ channel: m_tuser says whether a frame was shown, m_tdata gives
// its index and whether playback is still running afterwards.
// An accepted item is held in the input register and is evaluated as it
// moves into the output register, so the result is registered; a stall on
// the output holds the item in the input register until the result moves on.
// One item per cycle is sustained while m_tready stays high; the limit is the
// single state update per cycle in the sequencer core.
// Reset stops playback, rewinds to frame 0 and clears the deadline, sets the
// frame count to 1 and the loop limit to 0; delays must be written before a
// frame is played. When the receiver stalls, the result is held, the input
// register fills, and s_tready then drops until the output moves on.
// The cfg_ channel writes frame count (index 0) or loop limit (index 1) and
// is always ready; write it only while no item is in flight.
// ----------------------------------------------------------------------------
`include "animation_frame_sequencer_assert.svh"

module animation_frame_sequencer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // entry[3:0], delay_value[19:4], now_ms[51:20], zero pad
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // frame_shown[3:0], running[4], zero pad
    output logic        m_tuser,   // shown[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    afs_pkg::item_t   item_reg;
    logic             in_valid_reg;
    afs_pkg::result_t res_reg;
    afs_pkg::result_t res_next;
    logic             out_valid_reg;
    logic             advance;
    logic             step;
    logic             in_fire;

    logic [afs_pkg::FIU_W-1:0]  frames_in_use_reg;
    logic [afs_pkg::LOOP_W-1:0] loop_limit_reg;

    assign advance   = !out_valid_reg || m_tready;
    assign step      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= afs_pkg::FIU_W'(1);
            loop_limit_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == afs_pkg::CFG_FRAMES_IN_USE)
            begin
                frames_in_use_reg <= cfg_data[afs_pkg::FIU_W-1:0];
            end
            else
            begin
                loop_limit_reg <= cfg_data[afs_pkg::LOOP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.action      <= s_tuser;
            item_reg.entry       <= s_tdata[3:0];
            item_reg.delay_value <= s_tdata[19:4];
            item_reg.now_ms      <= s_tdata[51:20];
        end
    end

    afs_sequencer u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .item          (item_reg),
        .frames_in_use (frames_in_use_reg),
        .loop_limit    (loop_limit_reg),
        .result        (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.shown;
    assign m_tdata  = {3'b000, res_reg.running, res_reg.frame_shown};

    `AFS_ASSERT_SAME(a_no_overwrite, in_valid_reg && out_valid_reg && !m_tready, !s_tready)
    `AFS_ASSERT_NEXT(a_input_captured, in_fire, in_valid_reg)
    `AFS_ASSERT_NEXT(a_result_follows, step, m_tvalid)
    `AFS_ASSERT_SAME(a_frame_zero_unshown, m_tvalid && !m_tuser, m_tdata[3:0] == 4'd0)

endmodule
